// File: src/dual_motor_pwm_ramp_with_reversal_defines.svh
// Assertion macros for the dual motor PWM ramp block.
`ifndef DUAL_MOTOR_PWM_RAMP_WITH_REVERSAL_DEFINES_SVH
`define DUAL_MOTOR_PWM_RAMP_WITH_REVERSAL_DEFINES_SVH

// Implication checked on every rising clock edge, off while reset is high.
`define DMPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, but also evaluated while reset is high.
`define DMPR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/dmpr_pkg.sv
// Package for the dual motor PWM ramp block: widths, codes and the gamma ROM.
package dmpr_pkg;

   localparam int PWM_BITS         = 10;
   localparam int GAMMA_HUNDREDTHS = 200;
   localparam int SPEED_W          = 8;
   localparam int ROM_DEPTH        = 1 << SPEED_W;
   localparam int TICK_W           = 16;
   localparam int CSR_DATA_W       = 16;
   localparam int CSR_INDEX_W      = 1;

   typedef enum logic [1:0] {
      CMD_SET  = 2'd0,
      CMD_STOP = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLEW_STEP     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_INTERVAL = 1'b1;

   localparam logic [PWM_BITS-1:0]   SLEW_STEP_RST     = PWM_BITS'(16);
   localparam logic [TICK_W-1:0]     RAMP_INTERVAL_RST = TICK_W'(10);

   typedef logic [PWM_BITS-1:0] gamma_rom_type [ROM_DEPTH];

   // Integer square root, bit by bit.
   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      int          i;
      x = x_in;
      r = '0;
      b = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (b > x) b = b >> 2;
      end
      for (i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // log2 in unsigned Q16, fraction by repeated squaring of a Q30 mantissa.
   function automatic logic [63:0] log2_q16(input logic [31:0] v);
      logic [63:0] k;
      logic [63:0] m;
      logic [63:0] frac;
      int          i;
      k    = '0;
      frac = '0;
      for (i = 1; i < 32; i++) begin
         if ((v >> i) != 32'd0) k = 64'(i);
      end
      m = {32'd0, v} << (30 - k);
      for (i = 1; i <= 16; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | (64'd1 << (16 - i));
         end
      end
      return (k << 16) | frac;
   endfunction

   // Gamma table, worked out at elaboration.
   function automatic gamma_rom_type build_gamma_rom();
      gamma_rom_type rom;
      logic [63:0]   c [17];
      logic [63:0]   maxd;
      logic [63:0]   l255;
      logic [63:0]   lv;
      logic [63:0]   e;
      logic [63:0]   ip;
      logic [63:0]   fp;
      logic [63:0]   r;
      logic [63:0]   y;
      int            s;
      int            j;
      maxd = (64'd1 << PWM_BITS) - 64'd1;
      l255 = log2_q16(32'd255);
      c[0] = 64'd1 << 29;
      for (j = 1; j <= 16; j++) c[j] = isqrt64(c[j-1] << 30);
      rom[0]           = '0;
      rom[ROM_DEPTH-1] = maxd[PWM_BITS-1:0];
      for (s = 1; s < ROM_DEPTH - 1; s++) begin
         lv = l255 - log2_q16(32'(s));
         e  = (lv * 64'(GAMMA_HUNDREDTHS) + 64'd50) / 64'd100;
         ip = e >> 16;
         fp = e & 64'hFFFF;
         r  = 64'd1 << 30;
         for (j = 1; j <= 16; j++) begin
            if (fp[16-j]) r = (r * c[j]) >> 30;
         end
         if (ip > 64'd30) y = '0;
         else             y = (r * maxd + (64'd1 << (29 + ip))) >> (30 + ip);
         if (y > maxd) y = maxd;
         rom[s] = y[PWM_BITS-1:0];
      end
      return rom;
   endfunction

   localparam gamma_rom_type GAMMA_ROM = build_gamma_rom();

endpackage

// File: src/dual_motor_pwm_ramp_with_reversal.sv
// Top level: two-channel PWM slew limiter with direction reversal interlock.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+-------------------------
//  req     | req_cmd req_motor_sel req_speed req_forward | req_valid / req_stall
//  rsp     | rsp_pwm_one rsp_pwm_two rsp_dir_one rsp_dir_two | rsp_valid / rsp_stall
//  csr     | csr_index csr_wdata                      | csr_valid / csr_ready
//
// One transaction per cycle unless stalled. A request is applied to the channel
// state in the cycle it is accepted; the response carries the state after it and
// shows up on the next cycle. The state registers double as the response payload.
// req_stall is high only while a response is held and rsp_stall is high.
// Reset (synchronous, active high) clears duties, targets and pending flags,
// sets both directions forward and loads slew step 16, ramp_interval 10.
// csr_ready is always high; writes are expected only while the block is idle.
`include "dual_motor_pwm_ramp_with_reversal_defines.svh"

module dual_motor_pwm_ramp_with_reversal (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic                                req_motor_sel,
   input  logic [dmpr_pkg::SPEED_W-1:0]        req_speed,
   input  logic                                req_forward,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dmpr_pkg::PWM_BITS-1:0]       rsp_pwm_one,
   output logic [dmpr_pkg::PWM_BITS-1:0]       rsp_pwm_two,
   output logic                                rsp_dir_one,
   output logic                                rsp_dir_two,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dmpr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DW = dmpr_pkg::PWM_BITS;
   localparam int TW = dmpr_pkg::TICK_W;

   // config
   logic [DW-1:0] slew_step_ff;
   logic [TW-1:0] ramp_interval_ff;

   // per-channel state
   logic [DW-1:0] tgt_ff  [2];
   logic [DW-1:0] cur_ff  [2];
   logic [DW-1:0] des_ff  [2];
   logic          dir_ff  [2];
   logic          pend_ff [2];
   logic          pdir_ff [2];
   logic [TW-1:0] tick_ff;
   logic          rsp_valid_ff;

   logic [DW-1:0] tgt_in  [2];
   logic [DW-1:0] cur_in  [2];
   logic [DW-1:0] des_in  [2];
   logic          dir_in  [2];
   logic          pend_in [2];
   logic          pdir_in [2];
   logic [TW-1:0] tick_in;
   logic          rsp_valid_in;

   logic          req_accept;
   logic [TW:0]   tick_next;
   logic          step_now;
   logic [DW-1:0] duty_lu;
   logic [DW-1:0] diff [2];
   logic [DW-1:0] move [2];

   // Response register empties or drains this cycle -> take a request.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   assign duty_lu   = dmpr_pkg::GAMMA_ROM[req_speed];
   assign tick_next = {1'b0, tick_ff} + (TW+1)'(1);
   // interval of zero steps on every tick, same as the compare gives
   assign step_now  = tick_next >= {1'b0, ramp_interval_ff};

   always_comb begin
      tgt_in       = tgt_ff;
      cur_in       = cur_ff;
      des_in       = des_ff;
      dir_in       = dir_ff;
      pend_in      = pend_ff;
      pdir_in      = pdir_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      for (int ch = 0; ch < 2; ch++) begin
         diff[ch] = (cur_ff[ch] < tgt_ff[ch]) ? tgt_ff[ch] - cur_ff[ch]
                                              : cur_ff[ch] - tgt_ff[ch];
         move[ch] = (slew_step_ff < diff[ch]) ? slew_step_ff : diff[ch];
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         case (req_cmd)
            dmpr_pkg::CMD_SET: begin
               des_in[req_motor_sel] = duty_lu;
               if (duty_lu == '0) begin
                  pend_in[req_motor_sel] = 1'b0;
                  tgt_in[req_motor_sel]  = '0;
               end else if (req_forward == dir_ff[req_motor_sel]) begin
                  pend_in[req_motor_sel] = 1'b0;
                  tgt_in[req_motor_sel]  = duty_lu;
               end else begin
                  // opposite direction: ramp to zero first, flip later
                  pend_in[req_motor_sel] = 1'b1;
                  pdir_in[req_motor_sel] = req_forward;
                  tgt_in[req_motor_sel]  = '0;
               end
            end
            dmpr_pkg::CMD_STOP: begin
               for (int ch = 0; ch < 2; ch++) begin
                  tgt_in[ch]  = '0;
                  des_in[ch]  = '0;
                  pend_in[ch] = 1'b0;
               end
            end
            dmpr_pkg::CMD_TICK: begin
               if (step_now) begin
                  tick_in = '0;
                  for (int ch = 0; ch < 2; ch++) begin
                     if (cur_ff[ch] < tgt_ff[ch])      cur_in[ch] = cur_ff[ch] + move[ch];
                     else if (cur_ff[ch] > tgt_ff[ch]) cur_in[ch] = cur_ff[ch] - move[ch];
                     // reversal completes once the channel sits at zero
                     if (cur_in[ch] == '0 && pend_ff[ch]) begin
                        dir_in[ch]  = pdir_ff[ch];
                        pend_in[ch] = 1'b0;
                        tgt_in[ch]  = des_ff[ch];
                     end
                  end
               end else begin
                  tick_in = tick_next[TW-1:0];
               end
            end
            default: begin
               // unused command: state unchanged, response still issued
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_step_ff     <= dmpr_pkg::SLEW_STEP_RST;
         ramp_interval_ff <= dmpr_pkg::RAMP_INTERVAL_RST;
         tick_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int ch = 0; ch < 2; ch++) begin
            tgt_ff[ch]  <= '0;
            cur_ff[ch]  <= '0;
            des_ff[ch]  <= '0;
            dir_ff[ch]  <= 1'b1;
            pend_ff[ch] <= 1'b0;
            pdir_ff[ch] <= 1'b1;
         end
      end else begin
         tgt_ff       <= tgt_in;
         cur_ff       <= cur_in;
         des_ff       <= des_in;
         dir_ff       <= dir_in;
         pend_ff      <= pend_in;
         pdir_ff      <= pdir_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dmpr_pkg::CSR_SLEW_STEP:     slew_step_ff     <= csr_wdata[DW-1:0];
               dmpr_pkg::CSR_RAMP_INTERVAL: ramp_interval_ff <= csr_wdata[TW-1:0];
               default: ;
            endcase
         end
      end
   end

   // State is only updated on accept, and accept is blocked while a response
   // is held, so the state registers are the response payload.
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pwm_one = cur_ff[0];
   assign rsp_pwm_two = cur_ff[1];
   assign rsp_dir_one = dir_ff[0];
   assign rsp_dir_two = dir_ff[1];

   `DMPR_ASSERT(a_accept_gives_rsp, clock, reset, req_accept |=> rsp_valid_ff, "no response")
   `DMPR_ASSERT(a_pend0_tgt_zero, clock, reset, pend_ff[0] |-> (tgt_ff[0] == '0), "ch one target")
   `DMPR_ASSERT(a_pend1_tgt_zero, clock, reset, pend_ff[1] |-> (tgt_ff[1] == '0), "ch two target")
   `DMPR_ASSERT(a_held_duty, clock, reset, req_stall |=> $stable(cur_ff[0]) && $stable(cur_ff[1]), "duty moved")
   `DMPR_ASSERT_ALWAYS(a_csr_ready, clock, csr_ready, "csr_ready dropped")

endmodule

// File: bench/dmpr_checker.sv
// Drive-state predictor and response scoreboard for the dual motor PWM ramp block.
`timescale 1ns / 100ps

module dmpr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic                             req_motor_sel,
   input  logic [dmpr_pkg::SPEED_W-1:0]     req_speed,
   input  logic                             req_forward,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [dmpr_pkg::PWM_BITS-1:0]    rsp_pwm_one,
   input  logic [dmpr_pkg::PWM_BITS-1:0]    rsp_pwm_two,
   input  logic                             rsp_dir_one,
   input  logic                             rsp_dir_two,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [dmpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dmpr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               results_due
);

   localparam int PW = dmpr_pkg::PWM_BITS;
   localparam int TW = dmpr_pkg::TICK_W;

   typedef struct {
      logic [PW-1:0] pwm_one;
      logic [PW-1:0] pwm_two;
      logic          dir_one;
      logic          dir_two;
   } drive_snapshot_type;

   drive_snapshot_type drive_due_q [$];
   logic [PW-1:0]      gamma_lut [dmpr_pkg::ROM_DEPTH];

   logic [PW-1:0] tgt_duty  [2];
   logic [PW-1:0] cur_duty  [2];
   logic [PW-1:0] want_duty [2];
   logic          dir_state [2];
   logic          rev_pend  [2];
   logic          rev_dir   [2];
   logic [TW-1:0] tick_cnt;
   logic [PW-1:0] step_cfg;
   logic [TW-1:0] interval_cfg;

   // Q16 log2: integer part from the top set bit, fraction by squaring a Q30 mantissa.
   function automatic logic [63:0] log2_fixed(input logic [31:0] v);
      logic [63:0] k;
      logic [63:0] m;
      logic [63:0] frac;
      int          i;
      k    = '0;
      frac = '0;
      for (i = 0; i < 32; i++) begin
         if (v[i]) k = 64'(i);
      end
      m = {32'd0, v} << (30 - k);
      for (i = 1; i <= 16; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m    = m >> 1;
            frac = frac | (64'd1 << (16 - i));
         end
      end
      return (k << 16) | frac;
   endfunction

   task automatic check_field(input string label, input int exp_value, input int got_value);
      if (exp_value != got_value) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d",
                  $time, label, exp_value, got_value);
      end
   endtask

   // Gamma table: root chain of 2^-(1/2^j) in Q30, then 2^-E applied to full scale.
   initial begin : build_gamma
      logic [63:0] root_tab [17];
      logic [63:0] radicand;
      logic [63:0] root;
      logic [63:0] bit_w;
      logic [63:0] full_scale;
      logic [63:0] log_top;
      logic [63:0] expo;
      logic [63:0] ip;
      logic [63:0] scaled;
      logic [63:0] y;
      int          j;
      int          s;
      full_scale  = (64'd1 << PW) - 64'd1;
      log_top     = log2_fixed(32'd255);
      root_tab[0] = 64'd1 << 29;
      for (j = 1; j <= 16; j++) begin
         radicand = root_tab[j-1] << 30;
         root     = '0;
         bit_w    = 64'd1 << 62;
         while (bit_w > radicand) bit_w = bit_w >> 2;
         while (bit_w != 64'd0) begin
            if (radicand >= root + bit_w) begin
               radicand = radicand - (root + bit_w);
               root     = (root >> 1) + bit_w;
            end else begin
               root = root >> 1;
            end
            bit_w = bit_w >> 2;
         end
         root_tab[j] = root;
      end
      gamma_lut[0]   = '0;
      gamma_lut[255] = full_scale[PW-1:0];
      for (s = 1; s < 255; s++) begin
         expo   = ((log_top - log2_fixed(32'(s))) * 64'(dmpr_pkg::GAMMA_HUNDREDTHS)
                   + 64'd50) / 64'd100;
         ip     = expo >> 16;
         scaled = 64'd1 << 30;
         for (j = 1; j <= 16; j++) begin
            if (expo[16-j]) scaled = (scaled * root_tab[j]) >> 30;
         end
         if (ip > 64'd30) y = '0;
         else             y = (scaled * full_scale + (64'd1 << (29 + ip))) >> (30 + ip);
         if (y > full_scale) y = full_scale;
         gamma_lut[s] = y[PW-1:0];
      end
   end

   always @(posedge clock) begin : track
      drive_snapshot_type seen;
      drive_snapshot_type due;
      logic [PW-1:0]      duty;
      logic [PW-1:0]      gap;
      logic [TW:0]        next_cnt;
      int                 ch;
      if (reset) begin
         drive_due_q.delete();
         mismatch_count = 0;
         step_cfg       = dmpr_pkg::SLEW_STEP_RST;
         interval_cfg   = dmpr_pkg::RAMP_INTERVAL_RST;
         tick_cnt       = '0;
         for (ch = 0; ch < 2; ch++) begin
            tgt_duty[ch]  = '0;
            cur_duty[ch]  = '0;
            want_duty[ch] = '0;
            dir_state[ch] = 1'b1;
            rev_pend[ch]  = 1'b0;
            rev_dir[ch]   = 1'b1;
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_pwm_one, rsp_pwm_two, rsp_dir_one, rsp_dir_two};
            if (drive_due_q.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected response, expected none, got pwm %0d/%0d dir %0d/%0d",
                        $time, seen.pwm_one, seen.pwm_two, seen.dir_one, seen.dir_two);
            end else begin
               due = drive_due_q.pop_front();
               check_field("pwm_one", due.pwm_one, seen.pwm_one);
               check_field("pwm_two", due.pwm_two, seen.pwm_two);
               check_field("dir_one", due.dir_one, seen.dir_one);
               check_field("dir_two", due.dir_two, seen.dir_two);
            end
         end

         if (csr_valid && csr_ready) begin
            if (csr_index == dmpr_pkg::CSR_SLEW_STEP) step_cfg = csr_wdata[PW-1:0];
            else                                      interval_cfg = csr_wdata;
         end

         if (req_valid && !req_stall) begin
            case (req_cmd)
               dmpr_pkg::CMD_SET: begin
                  ch            = int'(req_motor_sel);
                  duty          = gamma_lut[req_speed];
                  want_duty[ch] = duty;
                  if (duty == '0) begin
                     rev_pend[ch] = 1'b0;
                     tgt_duty[ch] = '0;
                  end else if (req_forward == dir_state[ch]) begin
                     rev_pend[ch] = 1'b0;
                     tgt_duty[ch] = duty;
                  end else begin
                     // opposite direction: ramp down first, flip later
                     rev_pend[ch] = 1'b1;
                     rev_dir[ch]  = req_forward;
                     tgt_duty[ch] = '0;
                  end
               end
               dmpr_pkg::CMD_STOP: begin
                  for (ch = 0; ch < 2; ch++) begin
                     tgt_duty[ch]  = '0;
                     want_duty[ch] = '0;
                     rev_pend[ch]  = 1'b0;
                  end
               end
               dmpr_pkg::CMD_TICK: begin
                  next_cnt = {1'b0, tick_cnt} + 1'b1;
                  if (next_cnt >= {1'b0, interval_cfg}) begin
                     tick_cnt = '0;
                     for (ch = 0; ch < 2; ch++) begin
                        if (cur_duty[ch] < tgt_duty[ch]) begin
                           gap          = tgt_duty[ch] - cur_duty[ch];
                           cur_duty[ch] = cur_duty[ch] + ((step_cfg < gap) ? step_cfg : gap);
                        end else if (cur_duty[ch] > tgt_duty[ch]) begin
                           gap          = cur_duty[ch] - tgt_duty[ch];
                           cur_duty[ch] = cur_duty[ch] - ((step_cfg < gap) ? step_cfg : gap);
                        end
                        if (cur_duty[ch] == '0 && rev_pend[ch]) begin
                           dir_state[ch] = rev_dir[ch];
                           rev_pend[ch]  = 1'b0;
                           tgt_duty[ch]  = want_duty[ch];
                        end
                     end
                  end else begin
                     tick_cnt = next_cnt[TW-1:0];
                  end
               end
               default: ;
            endcase
            drive_due_q.push_back('{cur_duty[0], cur_duty[1], dir_state[0], dir_state[1]});
         end
      end
      results_due <= drive_due_q.size();
   end

endmodule

// File: bench/tb_top.sv
// Stimulus, clock, reset and verdict for the dual motor PWM ramp block.
`timescale 1ns / 100ps

module tb_top;

   // cmd 3 has no meaning; the block must leave its state alone
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int SW = dmpr_pkg::SPEED_W;
   localparam int PW = dmpr_pkg::PWM_BITS;
   localparam int IW = dmpr_pkg::CSR_INDEX_W;
   localparam int CW = dmpr_pkg::CSR_DATA_W;

   // Register settings walked by the random phases. Entry 0 is the reset
   // value; the others hit the extremes: max step, one-tick interval, zero
   // interval (every tick ramps), zero step, and a step word with junk in
   // the bits above the 10-bit field (0xFC05 lands as 5).
   localparam int STEP_WORDS     [8] = '{16, 1023, 1, 'hFC05, 64, 200, 0, 300};
   localparam int INTERVAL_WORDS [8] = '{10, 1, 1, 0, 2, 3, 1, 65535};

   // Idle mixes, one per phase in turn: none, sender only, receiver only, both.
   localparam int SEND_IDLE_PCT [4] = '{0, 60, 0, 37};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 60, 37};

   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS   = 106;

   logic          clock         = 1'b0;
   logic          reset         = 1'b1;
   logic          req_valid     = 1'b0;
   logic          req_stall;
   logic [1:0]    req_cmd       = '0;
   logic          req_motor_sel = 1'b0;
   logic [SW-1:0] req_speed     = '0;
   logic          req_forward   = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall     = 1'b0;
   logic [PW-1:0] rsp_pwm_one;
   logic [PW-1:0] rsp_pwm_two;
   logic          rsp_dir_one;
   logic          rsp_dir_two;
   logic          csr_valid     = 1'b0;
   logic          csr_ready;
   logic [IW-1:0] csr_index     = '0;
   logic [CW-1:0] csr_wdata     = '0;

   int mismatch_count;
   int results_due;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   always #10 clock = ~clock;

   dual_motor_pwm_ramp_with_reversal i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_motor_sel (req_motor_sel),
      .req_speed     (req_speed),
      .req_forward   (req_forward),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pwm_one   (rsp_pwm_one),
      .rsp_pwm_two   (rsp_pwm_two),
      .rsp_dir_one   (rsp_dir_one),
      .rsp_dir_two   (rsp_dir_two),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   dmpr_checker i_drive_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_motor_sel  (req_motor_sel),
      .req_speed      (req_speed),
      .req_forward    (req_forward),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pwm_one    (rsp_pwm_one),
      .rsp_pwm_two    (rsp_pwm_two),
      .rsp_dir_one    (rsp_dir_one),
      .rsp_dir_two    (rsp_dir_two),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   // Receiver back-pressure: a fresh coin every cycle, independent of rsp_valid.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Present one request and hold it until the DUT takes it. The sender may
   // idle first; valid stays high across back-to-back transactions, so it is
   // only lowered inside the idle loop or by drain_pipeline.
   task automatic send_request(input logic [1:0] op, input logic sel,
                               input logic [SW-1:0] spd, input logic fwd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= op;
      req_motor_sel <= sel;
      req_speed     <= spd;
      req_forward   <= fwd;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every response in flight has come back.
   // The first edge lets the checker count the transaction just accepted.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   // Both registers are rewritten back to back; csr_ready is sampled as the
   // handshake, even though the block ties it high today.
   task automatic load_ramp_regs(input int step_word, input int interval_word);
      csr_valid <= 1'b1;
      csr_index <= dmpr_pkg::CSR_SLEW_STEP;
      csr_wdata <= CW'(step_word);
      do @(posedge clock); while (!csr_ready);
      csr_index <= dmpr_pkg::CSR_RAMP_INTERVAL;
      csr_wdata <= CW'(interval_word);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Speeds lean on the two ends of the gamma table.
   function automatic logic [SW-1:0] pick_speed();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return SW'($urandom_range(255));
      endcase
   endfunction

   initial begin
      int         phase;
      int         counted;
      int         burst;
      int         k;
      logic [1:0] op;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed, part one: full step, zero interval, so every tick ramps and
      // a ramp covers the whole range in one step.
      load_ramp_regs(1023, 0);
      send_request(dmpr_pkg::CMD_SET, 1'b0, 8'd255, 1'b1);   // full scale forward
      send_request(dmpr_pkg::CMD_TICK, 1'b0, 8'd0, 1'b0);
      send_request(dmpr_pkg::CMD_SET, 1'b1, 8'd128, 1'b1);
      send_request(dmpr_pkg::CMD_TICK, 1'b1, 8'd0, 1'b0);
      send_request(dmpr_pkg::CMD_SET, 1'b0, 8'd255, 1'b0);   // reversal request, motor one
      send_request(dmpr_pkg::CMD_TICK, 1'b0, 8'd0, 1'b0);    // reaches 0 and flips
      send_request(dmpr_pkg::CMD_TICK, 1'b0, 8'd0, 1'b0);    // climbs back in reverse
      send_request(CMD_UNUSED, 1'b1, 8'd255, 1'b0);
      send_request(dmpr_pkg::CMD_STOP, 1'b1, 8'd255, 1'b1);
      send_request(dmpr_pkg::CMD_TICK, 1'b1, 8'd255, 1'b1);
      send_request(dmpr_pkg::CMD_SET, 1'b1, 8'd200, 1'b0);   // reversal already at duty 0
      send_request(dmpr_pkg::CMD_SET, 1'b0, 8'd0, 1'b1);     // speed 0 clears any pending flip
      send_request(dmpr_pkg::CMD_TICK, 1'b0, 8'd0, 1'b0);
      send_request(dmpr_pkg::CMD_TICK, 1'b0, 8'd0, 1'b0);
      drain_pipeline();

      // Directed, part two: zero step. Duties freeze, but a pending reversal
      // sitting at duty 0 still completes on the step.
      load_ramp_regs('hFC00, 1);
      send_request(dmpr_pkg::CMD_SET, 1'b0, 8'd255, 1'b1);
      send_request(dmpr_pkg::CMD_TICK, 1'b0, 8'd0, 1'b0);
      send_request(dmpr_pkg::CMD_TICK, 1'b1, 8'd0, 1'b1);
      send_request(dmpr_pkg::CMD_SET, 1'b1, 8'd1, 1'b1);     // smallest nonzero speed
      send_request(dmpr_pkg::CMD_TICK, 1'b0, 8'd0, 1'b0);
      drain_pipeline();

      // Random phases. Mostly a set followed by a burst of ticks so ramps
      // and reversals actually play out; the rest is loose noise over all
      // four command codes. Unused codes do not count toward the phase size.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_ramp_regs(STEP_WORDS[phase % 8], INTERVAL_WORDS[phase % 8]);
         send_idle_pct  = SEND_IDLE_PCT[phase % 4];
         recv_stall_pct = RECV_STALL_PCT[phase % 4];
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if ($urandom_range(99) < 80) begin
               if ($urandom_range(9) == 0) begin
                  send_request(dmpr_pkg::CMD_STOP, 1'($urandom_range(1)), pick_speed(),
                               1'($urandom_range(1)));
                  counted++;
               end
               send_request(dmpr_pkg::CMD_SET, 1'($urandom_range(1)), pick_speed(),
                            1'($urandom_range(1)));
               counted++;
               burst = $urandom_range(1, 40);
               for (k = 0; k < burst; k++) begin
                  send_request(dmpr_pkg::CMD_TICK, 1'($urandom_range(1)), pick_speed(),
                               1'($urandom_range(1)));
               end
               counted += burst;
            end else begin
               op = 2'($urandom_range(3));
               send_request(op, 1'($urandom_range(1)), pick_speed(), 1'($urandom_range(1)));
               if (op != CMD_UNUSED) counted++;
            end
         end
         drain_pipeline();
      end

      // Nothing left in flight; wait with the receiver ready so a stray response can still show.
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog, set far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
